/* sv/scc_pkg.sv */
// shared types and constants of the covariance and correlation block
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int XW        = 24;   // sample width
  localparam int CNT_W     = 11;   // pair count width
  localparam int SX_W      = 34;   // sum of samples
  localparam int SQ_W      = 57;   // sum of squares
  localparam int SXY_W     = 58;   // sum of cross products
  localparam int PROD_W    = 2 * XW;
  localparam int NW        = 68;   // n*S - S*S terms
  localparam int WIDE_W    = 200;  // shared adder width
  localparam int ITER_W    = 7;    // iteration counter, holds NW
  localparam int D_W       = 20;   // n*(n-1)
  localparam int COV_W     = 48;
  localparam int COR_W     = 32;
  localparam int C_BITS    = 31;   // correlation magnitude bits
  localparam int SQK_W     = 5;
  localparam int SHIFT_R   = 60;   // 2^60 scale of the root search
  localparam int MIN_PAIRS = 2;

  localparam logic [COV_W-1:0]  COV_POS_LIM = {1'b0, {(COV_W-1){1'b1}}};
  localparam logic [COV_W-1:0]  COV_NEG_LIM = {1'b1, {(COV_W-1){1'b0}}};
  localparam logic [C_BITS-1:0] COR_ONE     = {1'b1, {(C_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_ZERO_VAR = 2'd2
  } status_e;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_e;

  typedef struct packed {
    logic [COV_W-1:0] covariance;
    logic [COR_W-1:0] correlation;
    logic [CNT_W-1:0] pair_count;
    status_e          status;
  } scc_res_t;

endpackage

`default_nettype wire

/* sv/scc_if.sv */
// item channel interfaces for sample pairs and results
`timescale 1ns / 1ps
`default_nettype none

interface scc_in_if import scc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_sample;
  logic signed [XW-1:0] y_sample;
  logic                 last_pair;

  modport source (output valid, output x_sample, output y_sample, output last_pair,
                  input ready);
  modport sink (input valid, input x_sample, input y_sample, input last_pair,
                output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [COV_W-1:0] covariance;
  logic signed [COR_W-1:0] correlation;
  logic [CNT_W-1:0]        pair_count;
  logic [1:0]              status;

  modport source (output valid, output covariance, output correlation,
                  output pair_count, output status, input ready);
  modport sink (input valid, input covariance, input correlation,
                input pair_count, input status, output ready);
endinterface

`default_nettype wire

/* sv/scc_addsub.sv */
// shared wide adder and subtractor with carry out
`timescale 1ns / 1ps
`default_nettype none

module scc_addsub import scc_pkg::*; (
  input  logic [WIDE_W-1:0] a_i,
  input  logic [WIDE_W-1:0] b_i,
  input  op_e               op_i,
  output logic [WIDE_W-1:0] sum_o,
  output logic              carry_o
);

  logic [WIDE_W:0]   full;
  logic [WIDE_W-1:0] b_eff;
  logic              cin;

  assign cin   = (op_i == OP_SUB);
  assign b_eff = cin ? ~b_i : b_i;
  assign full  = {1'b0, a_i} + {1'b0, b_eff} + (WIDE_W + 1)'(cin);

  assign sum_o   = full[WIDE_W-1:0];
  assign carry_o = full[WIDE_W];

endmodule

`default_nettype wire

/* sv/scc_core.sv */
// accumulator and sequencer driving the shared adder
`timescale 1ns / 1ps
`default_nettype none

module scc_core import scc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [XW-1:0] x_sample_i,
  input  logic signed [XW-1:0] y_sample_i,
  input  logic                 last_pair_i,
  input  logic                 out_free_i,
  output logic                 res_push_o,
  output scc_res_t             res_o
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_ACC1 = 19'h00002,
    S_ACC2 = 19'h00004,
    S_ACC3 = 19'h00008,
    S_ACC4 = 19'h00010,
    S_FIN  = 19'h00020,
    S_LD   = 19'h00040,
    S_M1   = 19'h00080,
    S_M2   = 19'h00100,
    S_COMB = 19'h00200,
    S_ABS  = 19'h00400,
    S_DIV  = 19'h00800,
    S_SAT  = 19'h01000,
    S_PM   = 19'h02000,
    S_RM   = 19'h04000,
    S_SQ1  = 19'h08000,
    S_SQ2  = 19'h10000,
    S_SQ3  = 19'h20000,
    S_OUT  = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SX_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [SQ_W-1:0]         sxx_q, sxx_d, syy_q, syy_d;
  logic signed [SXY_W-1:0] sxy_q, sxy_d;

  logic signed [XW-1:0]     x_q, x_d, y_q, y_d;
  logic                     last_q, last_d, keep_q, keep_d;
  logic signed [PROD_W-1:0] prod_q, prod_d, mul_res;
  logic signed [XW-1:0]     mul_a, mul_b;
  logic [1:0]               k_q, k_d;
  logic [WIDE_W-1:0]        acc_q, acc_d, opa_q, opa_d;
  logic [NW-1:0]            mb_q, mb_d;
  logic [ITER_W-1:0]        iter_q, iter_d;
  logic signed [NW-1:0]     t_q, t_d, nxy_q, nxy_d, nxx_q, nxx_d, nyy_q, nyy_d;
  logic                     bneg_q, bneg_d, neg_q, neg_d;
  logic [NW-1:0]            mag_q, mag_d, q_q, q_d;
  logic [D_W-1:0]           d_q, d_d, rem_q, rem_d;
  logic [COV_W-1:0]         cov_q, cov_d;
  logic [COR_W-1:0]         cor_q, cor_d;
  status_e                  status_q, status_d;
  logic [WIDE_W-1:0]        pk2_q, pk2_d, f_q, f_d, dd_q, dd_d;
  logic [C_BITS-1:0]        c_q, c_d;
  logic [SQK_W-1:0]         sqk_q, sqk_d;

  logic [WIDE_W-1:0] add_a, add_b, add_sum;
  op_e               add_op;
  logic              add_carry;

  logic [WIDE_W-1:0]      p_sel, mstep_a, mstep_b;
  logic signed [SX_W-1:0] a_sel, b_sel;
  logic [SX_W-1:0]        b_abs;
  logic [2*CNT_W-1:0]     nn;
  logic                   cov_big;
  logic [COV_W-1:0]       cov_lim, cov_mag, cov_sat;
  logic [COR_W-1:0]       cor_abs;
  logic                   last_iter;

  scc_addsub u_addsub (
    .a_i     (add_a),
    .b_i     (add_b),
    .op_i    (add_op),
    .sum_o   (add_sum),
    .carry_o (add_carry)
  );

  assign mul_res = mul_a * mul_b;
  assign nn      = cnt_q * (cnt_q - 1'b1);

  always_comb begin
    unique case (k_q)
      2'd0: begin
        p_sel = WIDE_W'(sxy_q);
        a_sel = sx_q;
        b_sel = sy_q;
      end
      2'd1: begin
        p_sel = WIDE_W'(sxx_q);
        a_sel = sx_q;
        b_sel = sx_q;
      end
      default: begin
        p_sel = WIDE_W'(syy_q);
        a_sel = sy_q;
        b_sel = sy_q;
      end
    endcase
  end

  assign b_abs     = b_sel[SX_W-1] ? SX_W'(-b_sel) : SX_W'(b_sel);
  assign mstep_a   = {acc_q[WIDE_W-2:0], 1'b0};
  assign mstep_b   = mb_q[NW-1] ? opa_q : '0;
  assign last_iter = (iter_q == ITER_W'(1));

  // saturated covariance magnitude and sign
  assign cov_big = |q_q[NW-1:COV_W];
  assign cov_lim = neg_q ? COV_NEG_LIM : COV_POS_LIM;
  assign cov_mag = (cov_big || (q_q[COV_W-1:0] > cov_lim)) ? cov_lim : q_q[COV_W-1:0];
  assign cov_sat = neg_q ? (-cov_mag) : cov_mag;
  assign cor_abs = COR_W'(c_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    sxx_d    = sxx_q;
    syy_d    = syy_q;
    sxy_d    = sxy_q;
    x_d      = x_q;
    y_d      = y_q;
    last_d   = last_q;
    keep_d   = keep_q;
    prod_d   = prod_q;
    k_d      = k_q;
    acc_d    = acc_q;
    opa_d    = opa_q;
    mb_d     = mb_q;
    iter_d   = iter_q;
    t_d      = t_q;
    nxy_d    = nxy_q;
    nxx_d    = nxx_q;
    nyy_d    = nyy_q;
    bneg_d   = bneg_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    q_d      = q_q;
    d_d      = d_q;
    rem_d    = rem_q;
    cov_d    = cov_q;
    cor_d    = cor_q;
    status_d = status_q;
    pk2_d    = pk2_q;
    f_d      = f_q;
    dd_d     = dd_q;
    c_d      = c_q;
    sqk_d    = sqk_q;
    in_ready_o = 1'b0;
    res_push_o = 1'b0;
    mul_a  = x_q;
    mul_b  = x_q;
    add_a  = '0;
    add_b  = '0;
    add_op = OP_ADD;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d     = x_sample_i;
          y_d     = y_sample_i;
          last_d  = last_pair_i;
          keep_d  = (cnt_q < CNT_W'(MAX_SAMPLES));
          state_d = S_ACC1;
        end
      end
      S_ACC1: begin
        prod_d = mul_res;
        if (keep_q) begin
          cnt_d = cnt_q + 1'b1;
          sx_d  = sx_q + SX_W'(x_q);
          sy_d  = sy_q + SX_W'(y_q);
        end
        state_d = S_ACC2;
      end
      S_ACC2: begin
        mul_a  = y_q;
        mul_b  = y_q;
        prod_d = mul_res;
        if (keep_q) sxx_d = sxx_q + SQ_W'(prod_q);
        state_d = S_ACC3;
      end
      S_ACC3: begin
        mul_a  = x_q;
        mul_b  = y_q;
        prod_d = mul_res;
        if (keep_q) syy_d = syy_q + SQ_W'(prod_q);
        state_d = S_ACC4;
      end
      S_ACC4: begin
        if (keep_q) sxy_d = sxy_q + SXY_W'(prod_q);
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (cnt_q < CNT_W'(MIN_PAIRS)) begin
          status_d = ST_FEW;
          cov_d    = '0;
          cor_d    = '0;
          state_d  = S_OUT;
        end else begin
          d_d     = nn[D_W-1:0];
          k_d     = 2'd0;
          state_d = S_LD;
        end
      end
      S_LD: begin
        acc_d   = '0;
        opa_d   = p_sel;
        mb_d    = {cnt_q, {(NW-CNT_W){1'b0}}};
        iter_d  = ITER_W'(CNT_W);
        state_d = S_M1;
      end
      S_M1: begin
        add_a  = mstep_a;
        add_b  = mstep_b;
        acc_d  = add_sum;
        mb_d   = mb_q << 1;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          t_d     = add_sum[NW-1:0];
          acc_d   = '0;
          opa_d   = WIDE_W'(a_sel);
          mb_d    = {b_abs, {(NW-SX_W){1'b0}}};
          iter_d  = ITER_W'(SX_W);
          bneg_d  = b_sel[SX_W-1];
          state_d = S_M2;
        end
      end
      S_M2: begin
        add_a  = mstep_a;
        add_b  = mstep_b;
        acc_d  = add_sum;
        mb_d   = mb_q << 1;
        iter_d = iter_q - 1'b1;
        if (last_iter) state_d = S_COMB;
      end
      S_COMB: begin
        // n*S minus the product of the two sums
        add_a  = WIDE_W'(t_q);
        add_b  = acc_q;
        add_op = bneg_q ? OP_ADD : OP_SUB;
        unique case (k_q)
          2'd0:    nxy_d = add_sum[NW-1:0];
          2'd1:    nxx_d = add_sum[NW-1:0];
          default: nyy_d = add_sum[NW-1:0];
        endcase
        if (k_q == 2'd2) begin
          state_d = S_ABS;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_LD;
        end
      end
      S_ABS: begin
        add_b   = WIDE_W'(nxy_q);
        add_op  = OP_SUB;
        neg_d   = nxy_q[NW-1];
        mag_d   = nxy_q[NW-1] ? add_sum[NW-1:0] : nxy_q;
        mb_d    = nxy_q[NW-1] ? add_sum[NW-1:0] : nxy_q;
        rem_d   = '0;
        q_d     = '0;
        iter_d  = ITER_W'(NW);
        state_d = S_DIV;
      end
      S_DIV: begin
        add_a  = WIDE_W'({rem_q, mb_q[NW-1]});
        add_b  = WIDE_W'(d_q);
        add_op = OP_SUB;
        rem_d  = add_carry ? add_sum[D_W-1:0] : {rem_q[D_W-2:0], mb_q[NW-1]};
        q_d    = {q_q[NW-2:0], add_carry};
        mb_d   = mb_q << 1;
        iter_d = iter_q - 1'b1;
        if (last_iter) state_d = S_SAT;
      end
      S_SAT: begin
        cov_d = cov_sat;
        if ((nxx_q == '0) || (nyy_q == '0)) begin
          status_d = ST_ZERO_VAR;
          cor_d    = '0;
          state_d  = S_OUT;
        end else begin
          acc_d   = '0;
          opa_d   = WIDE_W'(unsigned'(nxx_q));
          mb_d    = nyy_q;
          iter_d  = ITER_W'(NW);
          state_d = S_PM;
        end
      end
      S_PM: begin
        add_a  = mstep_a;
        add_b  = mstep_b;
        acc_d  = add_sum;
        mb_d   = mb_q << 1;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          pk2_d   = add_sum << SHIFT_R;
          acc_d   = '0;
          opa_d   = WIDE_W'(mag_q);
          mb_d    = mag_q;
          iter_d  = ITER_W'(NW);
          state_d = S_RM;
        end
      end
      S_RM: begin
        add_a  = mstep_a;
        add_b  = mstep_b;
        acc_d  = add_sum;
        mb_d   = mb_q << 1;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          dd_d    = add_sum << SHIFT_R;
          f_d     = '0;
          c_d     = '0;
          sqk_d   = SQK_W'(C_BITS - 1);
          state_d = S_SQ1;
        end
      end
      S_SQ1: begin
        // growth of c^2 * P when the trial bit is set
        add_a   = f_q;
        add_b   = pk2_q;
        acc_d   = add_sum;
        state_d = S_SQ2;
      end
      S_SQ2: begin
        add_a  = dd_q;
        add_b  = acc_q;
        add_op = OP_SUB;
        if (add_carry) dd_d = add_sum;
        c_d     = {c_q[C_BITS-2:0], add_carry};
        state_d = S_SQ3;
      end
      S_SQ3: begin
        add_a = f_q >> 1;
        add_b = c_q[0] ? pk2_q : '0;
        f_d   = add_sum;
        pk2_d = pk2_q >> 2;
        if (sqk_q == '0) begin
          cor_d    = neg_q ? (-cor_abs) : cor_abs;
          status_d = ST_OK;
          state_d  = S_OUT;
        end else begin
          sqk_d   = sqk_q - 1'b1;
          state_d = S_SQ1;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          res_push_o = 1'b1;
          cnt_d      = '0;
          sx_d       = '0;
          sy_d       = '0;
          sxx_d      = '0;
          syy_d      = '0;
          sxy_d      = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.covariance  = cov_q;
  assign res_o.correlation = cor_q;
  assign res_o.pair_count  = cnt_q;
  assign res_o.status      = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      sxx_q   <= sxx_d;
      syy_q   <= syy_d;
      sxy_q   <= sxy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    last_q   <= last_d;
    keep_q   <= keep_d;
    prod_q   <= prod_d;
    k_q      <= k_d;
    acc_q    <= acc_d;
    opa_q    <= opa_d;
    mb_q     <= mb_d;
    iter_q   <= iter_d;
    t_q      <= t_d;
    nxy_q    <= nxy_d;
    nxx_q    <= nxx_d;
    nyy_q    <= nyy_d;
    bneg_q   <= bneg_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    q_q      <= q_d;
    d_q      <= d_d;
    rem_q    <= rem_d;
    cov_q    <= cov_d;
    cor_q    <= cor_d;
    status_q <= status_d;
    pk2_q    <= pk2_d;
    f_q      <= f_d;
    dd_q     <= dd_d;
    c_q      <= c_d;
    sqk_q    <= sqk_d;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SAMPLES))
    else $error("pair count above limit");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (cnt_q == '0) && (sx_q == '0) && (sxy_q == '0))
    else $error("sums not cleared after result");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < d_q))
    else $error("divider remainder out of range");

  a_cor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_o.status == ST_OK)) |-> (c_q <= COR_ONE))
    else $error("correlation magnitude above one");

endmodule

`default_nettype wire

/* sv/sample_covariance_correlation_top.sv */
// top level of the sample covariance and correlation block
//
//  channel | dir | payload                                       | handshake
//  in_i    | in  | x_sample, y_sample, last_pair                 | valid/ready
//  out_o   | out | covariance, correlation, pair_count, status   | valid/ready
//
// each item: accept, then four steps, three through the one 24x24 multiplier
// an item with last_pair then runs these steps on the shared 200-bit adder:
//   three 11+34 step products, a 68-step divide, two 68-step products, 31x3 root steps
// reset clears the count and sums at once; no clearing pass
// the result waits in an output register; the next item is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module sample_covariance_correlation_top import scc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scc_in_if.sink    in_i,
  scc_out_if.source out_o
);

  scc_res_t res, res_q;
  logic     res_push, out_valid_q, out_free;

  assign out_free = !out_valid_q || out_o.ready;

  scc_core #(.MAX_SAMPLES(MAX_SAMPLES)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .x_sample_i  (in_i.x_sample),
    .y_sample_i  (in_i.y_sample),
    .last_pair_i (in_i.last_pair),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_q <= res;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.covariance  = res_q.covariance;
  assign out_o.correlation = res_q.correlation;
  assign out_o.pair_count  = res_q.pair_count;
  assign out_o.status      = res_q.status;

endmodule

`default_nettype wire

/* test/tb_sample_covariance_correlation_top.sv */
// testbench: random and directed sample pair sets checked against a statistics predictor
`timescale 1ns / 1ps

module tb_sample_covariance_correlation_top;
  import scc_pkg::*;

  localparam int unsigned MAX_PAIRS   = 1024;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 4000;

  typedef struct {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 last;
  } pair_t;

  logic clk_i;
  logic rst_ni;

  scc_in_if  in_if ();
  scc_out_if out_if ();

  sample_covariance_correlation_top #(.MAX_SAMPLES(MAX_PAIRS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pair_t    pending_pairs[$];
  scc_res_t expected_stats[$];
  int       errors;
  int       results_seen;
  int       burst_left;
  int       gap_left;
  int       cycle_count;
  int       hold_left;
  bit       hold_done;

  // running sums of the open set
  int unsigned pair_cnt;
  longint      sum_x, sum_y, sum_xx, sum_yy, sum_xy;

  function automatic scc_res_t set_statistics();
    scc_res_t             r;
    logic signed [255:0]  nxy, nxx, nyy;
    logic [255:0]         mag, q, prod, rhs, lim;
    longint               lo, hi, mid;
    bit                   neg;
    r.pair_count  = pair_cnt[CNT_W-1:0];
    r.covariance  = '0;
    r.correlation = '0;
    if (pair_cnt < MIN_PAIRS) begin
      r.status = ST_FEW;
      return r;
    end
    nxy = 256'(signed'(longint'(pair_cnt))) * 256'(signed'(sum_xy))
        - 256'(signed'(sum_x)) * 256'(signed'(sum_y));
    nxx = 256'(signed'(longint'(pair_cnt))) * 256'(signed'(sum_xx))
        - 256'(signed'(sum_x)) * 256'(signed'(sum_x));
    nyy = 256'(signed'(longint'(pair_cnt))) * 256'(signed'(sum_yy))
        - 256'(signed'(sum_y)) * 256'(signed'(sum_y));
    neg = nxy < 0;
    mag = neg ? -nxy : nxy;
    q   = mag / (pair_cnt * (pair_cnt - 1));
    lim = neg ? (256'(1) << 47) : ((256'(1) << 47) - 1);
    if (q > lim) q = lim;
    r.covariance = neg ? -q[COV_W-1:0] : q[COV_W-1:0];
    if (nxx == 0 || nyy == 0) begin
      r.status = ST_ZERO_VAR;
      return r;
    end
    prod = nxx * nyy;
    rhs  = (mag * mag) << SHIFT_R;
    lo = 0;
    hi = longint'(1) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (256'(mid * mid) * prod <= rhs) lo = mid;
      else hi = mid - 1;
    end
    r.correlation = neg ? -lo[COR_W-1:0] : lo[COR_W-1:0];
    r.status      = ST_OK;
    return r;
  endfunction

  function automatic void accumulate_pair(pair_t p);
    longint xv, yv;
    xv = p.x;
    yv = p.y;
    if (pair_cnt < MAX_PAIRS) begin
      pair_cnt++;
      sum_x  += xv;
      sum_y  += yv;
      sum_xx += xv * xv;
      sum_yy += yv * yv;
      sum_xy += xv * yv;
    end
    if (p.last) begin
      expected_stats.push_back(set_statistics());
      pair_cnt = 0;
      sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
    end
  endfunction

  function automatic logic signed [XW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(XW-1){1'b0}}};
      1: return {1'b0, {(XW-1){1'b1}}};
      2: return XW'($urandom_range(0, 15)) - 8;
      default: return XW'($urandom);
    endcase
  endfunction

  task automatic add_pair(logic signed [XW-1:0] x, logic signed [XW-1:0] y, logic last);
    pair_t p;
    p.x = x; p.y = y; p.last = last;
    pending_pairs.push_back(p);
  endtask

  task automatic add_random_set(int len);
    logic signed [XW-1:0] cx;
    int                   shape;
    shape = $urandom_range(0, 9);
    cx = rand_sample();
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: add_pair(cx, rand_sample(), i == len - 1);        // constant x
        1: add_pair(XW'(i * 100), -XW'(i * 37), i == len - 1); // linear
        default: add_pair(rand_sample(), rand_sample(), i == len - 1);
      endcase
    end
  endtask

  localparam logic signed [XW-1:0] S_MIN = {1'b1, {(XW-1){1'b0}}};
  localparam logic signed [XW-1:0] S_MAX = {1'b0, {(XW-1){1'b1}}};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int total;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.x_sample = '0;
    in_if.y_sample = '0;
    in_if.last_pair = 1'b0;
    out_if.ready = 1'b0;
    errors = 0;
    pair_cnt = 0;
    sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;

    // single pair set
    add_pair(S_MAX, S_MIN, 1'b1);
    // large positive covariance, perfect positive correlation
    add_pair(S_MIN, S_MIN, 1'b0);
    add_pair(S_MAX, S_MAX, 1'b1);
    // large negative covariance, perfect negative correlation
    add_pair(S_MIN, S_MAX, 1'b0);
    add_pair(S_MAX, S_MIN, 1'b1);
    // zero variance in x, then in y
    add_pair(XW'(5), XW'(1), 1'b0);
    add_pair(XW'(5), XW'(-9), 1'b0);
    add_pair(XW'(5), XW'(3), 1'b1);
    add_pair(XW'(-1), XW'(0), 1'b0);
    add_pair(XW'(2), XW'(0), 1'b1);
    // all zero
    add_pair('0, '0, 1'b0);
    add_pair('0, '0, 1'b1);
    // mixed
    add_pair(XW'(4096), XW'(-4096), 1'b0);
    add_pair(XW'(-3), XW'(7), 1'b0);
    add_pair(XW'(12345), XW'(2), 1'b0);
    add_pair(S_MAX, XW'(-77), 1'b1);

    total = 0;
    while (total < 384) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
      add_random_set(len);
      total += len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni = 1'b1;

    while (pending_pairs.size() != 0 || in_if.valid || expected_stats.size() != 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        accumulate_pair(pending_pairs.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          in_if.valid     <= 1'b1;
          in_if.x_sample  <= pending_pairs[0].x;
          in_if.y_sample  <= pending_pairs[0].y;
          in_if.last_pair <= pending_pairs[0].last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold once a few results have come
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 4) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 1 || (!hold_done && results_seen >= 4)) begin
      out_if.ready <= 1'b0;
    end else begin
      case ((cycle_count / 300) % 3)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (out_if.valid && out_if.ready) begin
      scc_res_t e;
      results_seen <= results_seen + 1;
      if (expected_stats.size() == 0) begin
        $display("%0t unexpected result: cov %h cor %h n %0d status %0d", $time,
                 out_if.covariance, out_if.correlation, out_if.pair_count, out_if.status);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (out_if.covariance !== e.covariance) begin
          $display("%0t covariance: expected %h actual %h", $time, e.covariance,
                   out_if.covariance);
          errors++;
        end
        if (out_if.correlation !== e.correlation) begin
          $display("%0t correlation: expected %h actual %h", $time, e.correlation,
                   out_if.correlation);
          errors++;
        end
        if (out_if.pair_count !== e.pair_count) begin
          $display("%0t pair_count: expected %0d actual %0d", $time, e.pair_count,
                   out_if.pair_count);
          errors++;
        end
        if (out_if.status !== e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_if.status);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
